FILE: hw/rtl/sai_pkg.sv
package sai_pkg;

  localparam int DEPTH      = 256;
  localparam int VALUE_BITS = 20;
  localparam int COUNT_BITS = $clog2(DEPTH + 1);
  localparam int POS_BITS   = 8;
  localparam int GRP_SIZE   = 16;
  localparam int GRP_NUM    = DEPTH / GRP_SIZE;
  localparam int IN_BYTES   = (1 + VALUE_BITS + POS_BITS + 7) / 8;
  localparam int OUT_BYTES  = (2 + VALUE_BITS + COUNT_BITS + 7) / 8;

  typedef enum logic [0:0] {
    CMD_INSERT = 1'b0,
    CMD_REMOVE = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_STAGE,
    S_COMMIT,
    S_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic stage;
    logic commit;
  } ctrl_cmd_t;

endpackage

FILE: hw/rtl/sai_ctrl.sv
module sai_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output sai_pkg::ctrl_cmd_t   cmd
);

  sai_pkg::state_t state;
  sai_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sai_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    m_tvalid   = 1'b0;
    cmd        = '0;
    unique case (state)
      sai_pkg::S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = sai_pkg::S_STAGE;
        end
      end
      sai_pkg::S_STAGE: begin
        cmd.stage  = 1'b1;
        state_next = sai_pkg::S_COMMIT;
      end
      sai_pkg::S_COMMIT: begin
        cmd.commit = 1'b1;
        state_next = sai_pkg::S_OUT;
      end
      sai_pkg::S_OUT: begin
        m_tvalid = 1'b1;
        if (m_tready) begin
          state_next = sai_pkg::S_IDLE;
        end
      end
      default: state_next = sai_pkg::S_IDLE;
    endcase
  end

`ifndef ASSERT_OFF
  a_commit_then_out: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> m_tvalid)
    else $error("result not presented after commit");
  a_no_accept_while_out: assert property (@(posedge clk) disable iff (rst)
    !(m_tvalid && s_tready))
    else $error("input taken while a result is pending");
  a_load_then_stage: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> cmd.stage ##1 cmd.commit)
    else $error("item sequence broken");
`endif

endmodule

FILE: hw/rtl/sai_dpath.sv
module sai_dpath (
  input  logic                              clk,
  input  logic                              rst,
  input  sai_pkg::ctrl_cmd_t                cmd,
  input  logic                              in_command,
  input  logic [sai_pkg::VALUE_BITS-1:0]    in_value,
  input  logic [sai_pkg::POS_BITS-1:0]      in_position,
  output sai_pkg::status_t                  out_status,
  output logic [sai_pkg::VALUE_BITS-1:0]    out_removed,
  output logic [sai_pkg::COUNT_BITS-1:0]    out_fill
);

  logic [sai_pkg::VALUE_BITS-1:0] entries      [sai_pkg::DEPTH];
  logic [sai_pkg::VALUE_BITS-1:0] entries_next [sai_pkg::DEPTH];
  logic [sai_pkg::VALUE_BITS-1:0] grp          [sai_pkg::GRP_NUM];
  logic [sai_pkg::VALUE_BITS-1:0] grp_next     [sai_pkg::GRP_NUM];
  logic [sai_pkg::DEPTH-1:0]      lt;
  logic [sai_pkg::DEPTH-1:0]      lt_next;
  logic [sai_pkg::DEPTH-1:0]      ge_pos;
  logic [sai_pkg::DEPTH-1:0]      ge_pos_next;
  logic [sai_pkg::COUNT_BITS-1:0] count;
  logic [sai_pkg::COUNT_BITS-1:0] count_next;
  logic [sai_pkg::VALUE_BITS-1:0] removed_next;
  logic [sai_pkg::VALUE_BITS-1:0] value;
  logic [sai_pkg::POS_BITS-1:0]   position;
  sai_pkg::cmd_t                  command;
  logic                           full;
  logic                           range_err;
  logic                           do_insert;
  logic                           do_remove;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      command  <= sai_pkg::cmd_t'(in_command);
      value    <= in_value;
      position <= in_position;
    end
  end

  always_comb begin
    for (int k = 0; k < sai_pkg::DEPTH; k++) begin
      lt_next[k]     = (sai_pkg::COUNT_BITS'(k) < count) && (entries[k] < value);
      ge_pos_next[k] = sai_pkg::COUNT_BITS'(k) >= {1'b0, position};
    end
    for (int g = 0; g < sai_pkg::GRP_NUM; g++) begin
      grp_next[g] = '0;
      for (int j = 0; j < sai_pkg::GRP_SIZE; j++) begin
        if (position == sai_pkg::POS_BITS'(g * sai_pkg::GRP_SIZE + j)) begin
          grp_next[g] = grp_next[g] | entries[g * sai_pkg::GRP_SIZE + j];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.stage) begin
      lt        <= lt_next;
      ge_pos    <= ge_pos_next;
      grp       <= grp_next;
      full      <= count >= sai_pkg::COUNT_BITS'(sai_pkg::DEPTH);
      range_err <= {1'b0, position} >= count;
    end
  end

  assign do_insert = (command == sai_pkg::CMD_INSERT) && !full;
  assign do_remove = (command == sai_pkg::CMD_REMOVE) && !range_err;

  always_comb begin
    removed_next = '0;
    for (int g = 0; g < sai_pkg::GRP_NUM; g++) begin
      removed_next = removed_next | grp[g];
    end
    for (int k = 0; k < sai_pkg::DEPTH; k++) begin
      entries_next[k] = entries[k];
      if (do_insert && !lt[k]) begin
        if (k == 0) begin
          entries_next[k] = value;
        end else if (lt[(k + sai_pkg::DEPTH - 1) % sai_pkg::DEPTH]) begin
          entries_next[k] = value;
        end else begin
          entries_next[k] = entries[(k + sai_pkg::DEPTH - 1) % sai_pkg::DEPTH];
        end
      end else if (do_remove && ge_pos[k] && (k < sai_pkg::DEPTH - 1)) begin
        entries_next[k] = entries[(k + 1) % sai_pkg::DEPTH];
      end
    end
    count_next = count;
    if (do_insert) begin
      count_next = count + 1'b1;
    end else if (do_remove) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      entries <= entries_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.commit) begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_fill    <= count_next;
      out_removed <= do_remove ? removed_next : '0;
      if (command == sai_pkg::CMD_INSERT) begin
        out_status <= full ? sai_pkg::ST_FULL : sai_pkg::ST_DONE;
      end else begin
        out_status <= range_err ? sai_pkg::ST_RANGE : sai_pkg::ST_DONE;
      end
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= sai_pkg::COUNT_BITS'(sai_pkg::DEPTH))
    else $error("fill count beyond depth");
  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    cmd.commit && do_insert |=> count == $past(count) + 1'b1)
    else $error("insert did not grow the count");
  a_remove_shrinks: assert property (@(posedge clk) disable iff (rst)
    cmd.commit && do_remove |=> count == $past(count) - 1'b1)
    else $error("remove did not shrink the count");
  a_refused_holds: assert property (@(posedge clk) disable iff (rst)
    cmd.commit && !do_insert && !do_remove |=> $stable(count))
    else $error("refused item changed the count");
`endif

endmodule

FILE: hw/rtl/sorted_array_insert_remove_core.sv
// The result beat is presented once the accepted input beat has passed the
// stage and commit states; a new input is taken the cycle after the result
// beat is accepted, so the core takes no new item while one is in flight.
// The steps are capture, a parallel compare over the entry row with a grouped
// read of the removed entry, a shift of the whole row, and the output.
// Reset (rst, synchronous) clears the fill count and the controller; entry
// contents are left as they are and only entries below the count are read.
module sorted_array_insert_remove_core (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  // command [0], value [20:1], position [28:21], zero fill above
  input  logic [8*sai_pkg::IN_BYTES-1:0]  s_tdata,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  // status [1:0], removed_value [21:2], fill_count [30:22], zero fill above
  output logic [8*sai_pkg::OUT_BYTES-1:0] m_tdata
);

  sai_pkg::ctrl_cmd_t                 cmd;
  sai_pkg::status_t                   out_status;
  logic [sai_pkg::VALUE_BITS-1:0]     out_removed;
  logic [sai_pkg::COUNT_BITS-1:0]     out_fill;

  sai_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd)
  );

  sai_dpath u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .in_command  (s_tdata[0]),
    .in_value    (s_tdata[sai_pkg::VALUE_BITS:1]),
    .in_position (s_tdata[sai_pkg::VALUE_BITS+sai_pkg::POS_BITS:sai_pkg::VALUE_BITS+1]),
    .out_status  (out_status),
    .out_removed (out_removed),
    .out_fill    (out_fill)
  );

  assign m_tdata = (8*sai_pkg::OUT_BYTES)'({out_fill, out_removed, out_status});

endmodule
